### hdl/tension_pid_with_slack_detect_defines.svh
// assertion macros of the tension controller rtl, used by tpsd_pid
// expects signals named clk and rst_n in the module that uses them
`ifndef TENSION_PID_WITH_SLACK_DETECT_DEFINES_SVH
`define TENSION_PID_WITH_SLACK_DETECT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPSD_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TPSD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hdl/tpsd_pkg.sv
// shared types and constants of the cable tension pid controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tpsd_pkg;

    // field widths
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned LEVEL_W    = 15;
    localparam int unsigned ERR_W      = 18;
    localparam int unsigned ERRMAG_W   = 17;
    localparam int unsigned DIFF_W     = 19;
    localparam int unsigned INTEG_W    = 32;
    localparam int unsigned FRAC_SHIFT = 12;

    // register port
    localparam int unsigned PDATA_W    = 32;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned PADDR_W    = REG_IDX_W + 2;

    // item modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TARGET      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEADBAND    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLACK_LEVEL = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SLACK_SPEED = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED   = 3'd7;

    // register reset values
    localparam logic [GAIN_W-1:0]         RST_GAIN_P      = 16'd77;
    localparam logic [LEVEL_W-1:0]        RST_DEADBAND    = 15'd800;
    localparam logic [LEVEL_W-1:0]        RST_SLACK_LEVEL = 15'd960;
    localparam logic signed [SPEED_W-1:0] RST_SLACK_SPEED = 16'sd400;
    localparam logic [LEVEL_W-1:0]        RST_MAX_SPEED   = 15'd3000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] target_tension;
        logic [GAIN_W-1:0]          gain_p;
        logic [GAIN_W-1:0]          gain_i;
        logic [GAIN_W-1:0]          gain_d;
        logic [LEVEL_W-1:0]         deadband;
        logic [LEVEL_W-1:0]         slack_level;
        logic signed [SPEED_W-1:0]  slack_speed;
        logic [LEVEL_W-1:0]         max_speed;
    } cfg_t;

    typedef struct packed {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      slack;
    } result_t;

endpackage

`default_nettype wire

### hdl/tpsd_cfg.sv
// register file of the tension controller on a simple apb-style port
// depends on tpsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpsd_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tpsd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tpsd_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tpsd_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output tpsd_pkg::cfg_t                      cfg
);

    tpsd_pkg::cfg_t                       cfg_reg;
    tpsd_pkg::cfg_t                       cfg_next;
    logic                                 wr_en;
    logic [tpsd_pkg::REG_IDX_W-1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[tpsd_pkg::PADDR_W-1:2];
    assign cfg     = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                tpsd_pkg::REG_TARGET:
                    cfg_next.target_tension = pwdata[tpsd_pkg::SAMPLE_W-1:0];
                tpsd_pkg::REG_GAIN_P:      cfg_next.gain_p = pwdata[tpsd_pkg::GAIN_W-1:0];
                tpsd_pkg::REG_GAIN_I:      cfg_next.gain_i = pwdata[tpsd_pkg::GAIN_W-1:0];
                tpsd_pkg::REG_GAIN_D:      cfg_next.gain_d = pwdata[tpsd_pkg::GAIN_W-1:0];
                tpsd_pkg::REG_DEADBAND:
                    cfg_next.deadband = pwdata[tpsd_pkg::LEVEL_W-1:0];
                tpsd_pkg::REG_SLACK_LEVEL:
                    cfg_next.slack_level = pwdata[tpsd_pkg::LEVEL_W-1:0];
                tpsd_pkg::REG_SLACK_SPEED:
                    cfg_next.slack_speed = pwdata[tpsd_pkg::SPEED_W-1:0];
                tpsd_pkg::REG_MAX_SPEED:
                    cfg_next.max_speed = pwdata[tpsd_pkg::LEVEL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_tension <= '0;
            cfg_reg.gain_p         <= tpsd_pkg::RST_GAIN_P;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.deadband       <= tpsd_pkg::RST_DEADBAND;
            cfg_reg.slack_level    <= tpsd_pkg::RST_SLACK_LEVEL;
            cfg_reg.slack_speed    <= tpsd_pkg::RST_SLACK_SPEED;
            cfg_reg.max_speed      <= tpsd_pkg::RST_MAX_SPEED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux, raw register bits
    always_comb
    begin
        case (reg_idx)
            tpsd_pkg::REG_TARGET:
                prdata = tpsd_pkg::PDATA_W'(unsigned'(cfg_reg.target_tension));
            tpsd_pkg::REG_GAIN_P:      prdata = tpsd_pkg::PDATA_W'(cfg_reg.gain_p);
            tpsd_pkg::REG_GAIN_I:      prdata = tpsd_pkg::PDATA_W'(cfg_reg.gain_i);
            tpsd_pkg::REG_GAIN_D:      prdata = tpsd_pkg::PDATA_W'(cfg_reg.gain_d);
            tpsd_pkg::REG_DEADBAND:    prdata = tpsd_pkg::PDATA_W'(cfg_reg.deadband);
            tpsd_pkg::REG_SLACK_LEVEL: prdata = tpsd_pkg::PDATA_W'(cfg_reg.slack_level);
            tpsd_pkg::REG_SLACK_SPEED:
                prdata = tpsd_pkg::PDATA_W'(unsigned'(cfg_reg.slack_speed));
            tpsd_pkg::REG_MAX_SPEED:   prdata = tpsd_pkg::PDATA_W'(cfg_reg.max_speed);
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/tpsd_window.sv
// sample window of the tension controller: shift line, running sum, slack check
// depends on tpsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpsd_window #(
    parameter int unsigned WINDOW = 10
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire logic                                               shift_en,
    input  wire logic signed [tpsd_pkg::SAMPLE_W-1:0]               sample,
    input  wire logic [tpsd_pkg::LEVEL_W-1:0]                       slack_level,
    output logic signed [tpsd_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]     sum,
    output logic                                                    slack
);

    localparam int unsigned SUM_W = tpsd_pkg::SAMPLE_W + $clog2(WINDOW);

    logic signed [tpsd_pkg::SAMPLE_W-1:0] tap_reg [WINDOW];
    logic signed [SUM_W-1:0]              sum_reg;
    logic signed [SUM_W-1:0]              sum_next;
    logic signed [tpsd_pkg::SAMPLE_W-1:0] level_s;

    // the oldest reading drops out as the new one enters
    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(tap_reg[WINDOW-1]);
    assign sum      = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                tap_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (shift_en)
        begin
            tap_reg[0] <= sample;
            for (int i = 1; i < WINDOW; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    // slack when no reading rises above the level
    assign level_s = $signed({1'b0, slack_level});

    always_comb
    begin
        slack = 1'b1;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (tap_reg[i] > level_s)
            begin
                slack = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/tpsd_pid.sv
// control tick pipeline: mean error, deadband, integral, pid products, clamp
// depends on tpsd_pkg and tension_pid_with_slack_detect_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "tension_pid_with_slack_detect_defines.svh"

module tpsd_pid #(
    parameter int unsigned WINDOW = 10
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire tpsd_pkg::cfg_t                                     cfg,
    input  wire logic                                               tick_valid,
    output logic                                                    tick_ready,
    input  wire logic signed [tpsd_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] window_sum,
    input  wire logic                                               window_slack,
    output logic                                                    result_valid,
    input  wire logic                                               result_stall,
    output tpsd_pkg::result_t                                       result
);

    localparam int unsigned LOG_W   = $clog2(WINDOW);
    localparam int unsigned SUM_W   = tpsd_pkg::SAMPLE_W + LOG_W;
    localparam int unsigned EW_W    = SUM_W + 1;
    localparam int unsigned MAG_W   = EW_W;
    localparam int unsigned K       = MAG_W + LOG_W;
    localparam int unsigned RCP_W   = MAG_W + 1;
    localparam int unsigned PROD_W  = MAG_W + RCP_W;
    localparam int unsigned P_W     = tpsd_pkg::GAIN_W + 1 + tpsd_pkg::ERR_W;
    localparam int unsigned I_W     = tpsd_pkg::GAIN_W + 1 + tpsd_pkg::INTEG_W;
    localparam int unsigned D_W     = tpsd_pkg::GAIN_W + 1 + tpsd_pkg::DIFF_W;
    localparam int unsigned ACC_W   = I_W + 2;
    localparam int unsigned AMAG_W  = ACC_W - tpsd_pkg::FRAC_SHIFT;
    localparam int unsigned ISUM_W  = tpsd_pkg::INTEG_W + 1;

    // rounded divide by the window length as a reciprocal multiply, exact for MAG_W bits
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [MAG_W-1:0]       HALF_W = MAG_W'(WINDOW / 2);
    localparam logic signed [EW_W-1:0] WIN_C  = EW_W'(WINDOW);
    localparam logic signed [tpsd_pkg::INTEG_W-1:0] INTEG_MAX =
        {1'b0, {(tpsd_pkg::INTEG_W-1){1'b1}}};
    localparam logic signed [tpsd_pkg::INTEG_W-1:0] INTEG_MIN =
        {1'b1, {(tpsd_pkg::INTEG_W-1){1'b0}}};

    // stage valids and readiness
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;
    logic result_valid_reg;
    tpsd_pkg::result_t result_reg;

    assign rdy_out    = !result_valid_reg || !result_stall;
    assign rdy4       = !v4_reg || rdy_out;
    assign rdy3       = !v3_reg || rdy4;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign tick_ready = rdy1;

    // stage 1: scaled target minus window sum
    logic signed [EW_W-1:0] ew_c;
    logic signed [EW_W-1:0] ew1_reg;
    logic                   slack1_reg;

    assign ew_c = EW_W'(cfg.target_tension) * WIN_C - EW_W'(window_sum);

    // stage 2: rounded magnitude times reciprocal
    logic                    ew_neg;
    logic [MAG_W-1:0]        ew_abs;
    logic [MAG_W-1:0]        ew_round;
    logic [PROD_W-1:0]       prod_c;
    logic [PROD_W-1:0]       prod2_reg;
    logic                    neg2_reg;
    logic                    slack2_reg;

    assign ew_neg   = ew1_reg[EW_W-1];
    assign ew_abs   = ew_neg ? MAG_W'(-ew1_reg) : MAG_W'(ew1_reg);
    assign ew_round = ew_abs + HALF_W;
    assign prod_c   = PROD_W'(ew_round) * PROD_W'(RECIP);

    // stage 3: error, deadband, integral and derivative terms
    logic [tpsd_pkg::ERRMAG_W-1:0]         err_mag;
    logic signed [tpsd_pkg::ERR_W-1:0]     err_c;
    logic                                  inband_c;
    logic signed [ISUM_W-1:0]              integ_sum;
    logic signed [tpsd_pkg::INTEG_W-1:0]   integ_c;
    logic signed [tpsd_pkg::DIFF_W-1:0]    diff_c;
    logic signed [tpsd_pkg::INTEG_W-1:0]   error_integral_reg;
    logic signed [tpsd_pkg::ERR_W-1:0]     previous_error_reg;
    logic signed [tpsd_pkg::ERR_W-1:0]     err3_reg;
    logic signed [tpsd_pkg::INTEG_W-1:0]   integ3_reg;
    logic signed [tpsd_pkg::DIFF_W-1:0]    diff3_reg;
    logic                                  inband3_reg;
    logic                                  slack3_reg;
    logic                                  state_upd;

    assign err_mag  = prod2_reg[K +: tpsd_pkg::ERRMAG_W];
    assign err_c    = neg2_reg ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
    assign inband_c = err_mag <= tpsd_pkg::ERRMAG_W'(cfg.deadband);
    assign integ_sum = ISUM_W'(error_integral_reg) + ISUM_W'(err_c);
    assign diff_c   = tpsd_pkg::DIFF_W'(err_c) - tpsd_pkg::DIFF_W'(previous_error_reg);
    assign state_upd = v2_reg && rdy3 && !inband_c;

    // saturate the integral to the signed 32-bit range
    always_comb
    begin
        if (integ_sum[ISUM_W-1] != integ_sum[ISUM_W-2])
        begin
            integ_c = integ_sum[ISUM_W-1] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            integ_c = integ_sum[tpsd_pkg::INTEG_W-1:0];
        end
    end

    // stage 4: the three gain products
    logic signed [P_W-1:0] p_c, p4_reg;
    logic signed [I_W-1:0] i_c, i4_reg;
    logic signed [D_W-1:0] d_c, d4_reg;
    logic                  inband4_reg;
    logic                  slack4_reg;

    assign p_c = P_W'($signed({1'b0, cfg.gain_p})) * P_W'(err3_reg);
    assign i_c = I_W'($signed({1'b0, cfg.gain_i})) * I_W'(integ3_reg);
    assign d_c = D_W'($signed({1'b0, cfg.gain_d})) * D_W'(diff3_reg);

    // output stage: sum, truncate toward zero, deadband zero, slack override, clamp
    logic signed [ACC_W-1:0]            acc;
    logic                               acc_neg;
    logic [ACC_W-1:0]                   acc_abs;
    logic [AMAG_W-1:0]                  acc_mag;
    logic [tpsd_pkg::LEVEL_W-1:0]       pid_lim;
    logic [tpsd_pkg::SPEED_W-1:0]       pid_lim_w;
    logic signed [tpsd_pkg::SPEED_W-1:0] pid_spd;
    logic signed [tpsd_pkg::SPEED_W:0]  ss_ext;
    logic signed [tpsd_pkg::SPEED_W:0]  max_pos;
    logic signed [tpsd_pkg::SPEED_W:0]  max_neg;
    logic signed [tpsd_pkg::SPEED_W-1:0] slack_spd;
    logic signed [tpsd_pkg::SPEED_W-1:0] spd_c;

    assign acc       = ACC_W'(p4_reg) + ACC_W'(i4_reg) + ACC_W'(d4_reg);
    assign acc_neg   = acc[ACC_W-1];
    assign acc_abs   = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);
    assign acc_mag   = acc_abs[ACC_W-1:tpsd_pkg::FRAC_SHIFT];
    assign pid_lim   = (acc_mag > AMAG_W'(cfg.max_speed)) ?
                       cfg.max_speed : acc_mag[tpsd_pkg::LEVEL_W-1:0];
    assign pid_lim_w = {1'b0, pid_lim};
    assign pid_spd   = acc_neg ? $signed(-pid_lim_w) : $signed(pid_lim_w);

    assign ss_ext  = {cfg.slack_speed[tpsd_pkg::SPEED_W-1], cfg.slack_speed};
    assign max_pos = $signed({2'b00, cfg.max_speed});
    assign max_neg = -max_pos;

    always_comb
    begin
        if (ss_ext > max_pos)
        begin
            slack_spd = max_pos[tpsd_pkg::SPEED_W-1:0];
        end
        else if (ss_ext < max_neg)
        begin
            slack_spd = max_neg[tpsd_pkg::SPEED_W-1:0];
        end
        else
        begin
            slack_spd = cfg.slack_speed;
        end
    end

    always_comb
    begin
        if (inband4_reg)
        begin
            spd_c = '0;
        end
        else if (slack4_reg)
        begin
            spd_c = slack_spd;
        end
        else
        begin
            spd_c = pid_spd;
        end
    end

    // stage valid bits and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg             <= 1'b0;
            v2_reg             <= 1'b0;
            v3_reg             <= 1'b0;
            v4_reg             <= 1'b0;
            result_valid_reg   <= 1'b0;
            error_integral_reg <= '0;
            previous_error_reg <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= tick_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy_out)
            begin
                result_valid_reg <= v4_reg;
            end
            if (state_upd)
            begin
                error_integral_reg <= integ_c;
                previous_error_reg <= err_c;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy1 && tick_valid)
        begin
            ew1_reg    <= ew_c;
            slack1_reg <= window_slack;
        end
        if (rdy2 && v1_reg)
        begin
            prod2_reg  <= prod_c;
            neg2_reg   <= ew_neg;
            slack2_reg <= slack1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            err3_reg    <= err_c;
            integ3_reg  <= integ_c;
            diff3_reg   <= diff_c;
            inband3_reg <= inband_c;
            slack3_reg  <= slack2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            p4_reg      <= p_c;
            i4_reg      <= i_c;
            d4_reg      <= d_c;
            inband4_reg <= inband3_reg;
            slack4_reg  <= slack3_reg;
        end
        if (rdy_out && v4_reg)
        begin
            result_reg.speed <= spd_c;
            result_reg.slack <= slack4_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `TPSD_ASSERT_NOW(a_speed_clamped, result_valid_reg,
        ($signed(result_reg.speed) <= $signed({1'b0, cfg.max_speed})) &&
        ($signed(result_reg.speed) >= -$signed({1'b0, cfg.max_speed})),
        "speed beyond clamp")
    `TPSD_ASSERT_NEXT(a_deadband_holds_integral, v2_reg && rdy3 && inband_c,
        $stable(error_integral_reg) && $stable(previous_error_reg),
        "integral moved inside deadband")
    `TPSD_ASSERT_NEXT(a_last_stage_delivers, v4_reg && rdy_out, result_valid_reg,
        "tick lost at output register")

endmodule

`default_nettype wire

### hdl/tension_pid_with_slack_detect.sv
// Cable tension controller channel. Each input beat carries a mode bit and a signed
// Q12.4 sample: a sample beat shifts the reading into a window of the last WINDOW
// readings and yields no result, a tick beat yields exactly one result beat with the
// clamped speed command and the slack flag. One beat is taken every cycle with no
// gaps while result beats are taken as they come; a stalled result backs up the tick
// pipeline and then the input. A tick's result passes through an input register,
// four compute stages (scaled target minus window sum, mean error by reciprocal
// multiply, deadband and integral update, gain products) and the output register,
// which sums, truncates and clamps. The window sum is kept as a running total so a
// tick never adds up the window. Registers sit on the apb port at byte address
// 4*index: target, gain_p, gain_i, gain_d, deadband, slack_level, slack_speed,
// max_speed; write them only while the block is idle.
// depends on tpsd_pkg, tpsd_cfg, tpsd_window, tpsd_pid
`timescale 1ns / 1ps
`default_nettype none

module tension_pid_with_slack_detect #(
    parameter int unsigned WINDOW = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire tpsd_pkg::item_t                item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output tpsd_pkg::result_t                   result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tpsd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tpsd_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tpsd_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int unsigned SUM_W = tpsd_pkg::SAMPLE_W + $clog2(WINDOW);

    tpsd_pkg::cfg_t          cfg;
    tpsd_pkg::item_t         item_reg;
    logic                    v0_reg;
    logic                    s0_adv;
    logic                    item_accept;
    logic                    shift_en;
    logic                    tick_valid;
    logic                    tick_ready;
    logic signed [SUM_W-1:0] window_sum;
    logic                    window_slack;

    // input register: samples retire at once, ticks wait for the pipeline
    assign shift_en    = v0_reg && (item_reg.mode == tpsd_pkg::MODE_SAMPLE);
    assign tick_valid  = v0_reg && (item_reg.mode == tpsd_pkg::MODE_TICK);
    assign s0_adv      = shift_en || (tick_valid && tick_ready);
    assign item_stall  = v0_reg && !s0_adv;
    assign item_accept = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            v0_reg <= 1'b1;
        end
        else if (s0_adv)
        begin
            v0_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg <= item;
        end
    end

    // configuration registers
    tpsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sample window
    tpsd_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (shift_en),
        .sample      (item_reg.sample),
        .slack_level (cfg.slack_level),
        .sum         (window_sum),
        .slack       (window_slack)
    );

    // tick pipeline
    tpsd_pid #(
        .WINDOW (WINDOW)
    ) u_pid (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .window_sum   (window_sum),
        .window_slack (window_slack),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
